// ===== rtl/mlpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpd_pkg
// Shared types and constants of the sync-byte, length-prefixed deframer.
// ----------------------------------------------------------------------------
package mlpd_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h99;
	localparam logic [7:0] MIN_LEN   = 8'd4;
	localparam int         HDR_BYTES = 4;
	localparam logic [1:0] LAST_IDX  = 2'(HDR_BYTES - 1);

	// one queue entry: a whole header (four bytes) or a single body byte in data[0]
	typedef struct packed {
		logic                          hdr;
		logic                          last;
		logic [HDR_BYTES-1:0][7:0]     data;
	} mlpd_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mlpd_fifo_stat_t;

endpackage

// ===== rtl/mlpd_if.sv =====
// ----------------------------------------------------------------------------
// mlpd_if
// Valid/ready channels of the deframer: raw byte stream and packet bytes.
// ----------------------------------------------------------------------------
interface mlpd_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface mlpd_pkt_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, output out_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input out_byte, input first_byte, input last_byte,
		output ready);
endinterface

// ===== rtl/mlpd_front.sv =====
// ----------------------------------------------------------------------------
// mlpd_front
// Takes raw bytes, hunts for sync, checks the header length and queues
// whole headers or single body bytes for the back end.
// ----------------------------------------------------------------------------
module mlpd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	mlpd_raw_if.sink                  raw,
	input  mlpd_pkg::mlpd_fifo_stat_t q_stat,
	output logic                      push,
	output mlpd_pkg::mlpd_entry_t     push_entry
);
	import mlpd_pkg::*;

	logic [2:0][7:0] win_q, win_n;
	logic [1:0]      fill_q, fill_n;
	logic            in_pkt_q, in_pkt_n;
	logic [7:0]      left_q, left_n;
	logic            acc;
	logic [7:0]      b;

	assign raw.ready = !q_stat.full;
	assign acc       = raw.valid && raw.ready;
	assign b         = raw.data_byte;

	always_comb begin
		win_n      = win_q;
		fill_n     = fill_q;
		in_pkt_n   = in_pkt_q;
		left_n     = left_q;
		push       = 1'b0;
		push_entry = '{hdr: 1'b0, last: 1'b0, data: {HDR_BYTES{b}}};
		if (acc) begin
			if (in_pkt_q) begin
				push            = 1'b1;
				push_entry.last = (left_q <= 8'd1);
				if (left_q <= 8'd1) begin
					in_pkt_n = 1'b0;
					left_n   = '0;
				end else begin
					left_n = left_q - 8'd1;
				end
			end else if (fill_q == 2'd0) begin
				if (b == SYNC_BYTE) begin
					win_n[0] = b;
					fill_n   = 2'd1;
				end
			end else if (fill_q != 2'd3) begin
				win_n[fill_q] = b;
				fill_n        = fill_q + 2'd1;
			end else if (win_q[2] < MIN_LEN) begin
				// bad length: drop the sync byte, resync inside the held bytes
				priority if (win_q[1] == SYNC_BYTE) begin
					win_n  = {b, win_q[2], win_q[1]};
					fill_n = 2'd3;
				end else if (win_q[2] == SYNC_BYTE) begin
					win_n[0] = win_q[2];
					win_n[1] = b;
					fill_n   = 2'd2;
				end else if (b == SYNC_BYTE) begin
					win_n[0] = b;
					fill_n   = 2'd1;
				end else begin
					fill_n = 2'd0;
				end
			end else begin
				push            = 1'b1;
				push_entry.hdr  = 1'b1;
				push_entry.data = {b, win_q[2], win_q[1], win_q[0]};
				push_entry.last = (win_q[2] == MIN_LEN);
				fill_n          = 2'd0;
				if (win_q[2] != MIN_LEN) begin
					in_pkt_n = 1'b1;
					left_n   = win_q[2] - MIN_LEN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			in_pkt_q <= 1'b0;
			left_q   <= '0;
		end else begin
			fill_q   <= fill_n;
			in_pkt_q <= in_pkt_n;
			left_q   <= left_n;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_n;
	end

endmodule

// ===== rtl/mlpd_fifo.sv =====
// ----------------------------------------------------------------------------
// mlpd_fifo
// Short queue of header and body entries between front and back ends.
// ----------------------------------------------------------------------------
module mlpd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  mlpd_pkg::mlpd_entry_t     wr_entry,
	input  logic                      pop,
	output mlpd_pkg::mlpd_entry_t     rd_entry,
	output mlpd_pkg::mlpd_fifo_stat_t stat
);
	import mlpd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mlpd_entry_t   mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign rd_entry   = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

endmodule

// ===== rtl/mlpd_back.sv =====
// ----------------------------------------------------------------------------
// mlpd_back
// Unrolls queued entries into one packet byte per cycle while pkt is ready,
// behind an output register, marking the first and last byte of each packet.
// ----------------------------------------------------------------------------
module mlpd_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mlpd_pkg::mlpd_entry_t     head,
	input  mlpd_pkg::mlpd_fifo_stat_t q_stat,
	output logic                      pop,
	mlpd_pkt_if.source                pkt
);
	import mlpd_pkg::*;

	logic [1:0] idx_q;
	logic       vld_q;
	logic [7:0] byte_q;
	logic       first_q, last_q;
	logic       load;
	logic       head_done;

	assign load      = !q_stat.empty && (!vld_q || pkt.ready);
	assign head_done = !head.hdr || (idx_q == LAST_IDX);
	assign pop       = load && head_done;

	assign pkt.valid      = vld_q;
	assign pkt.out_byte   = byte_q;
	assign pkt.first_byte = first_q;
	assign pkt.last_byte  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= head_done ? 2'd0 : idx_q + 2'd1;
			end else if (pkt.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= head.data[idx_q];
			first_q <= head.hdr && (idx_q == 2'd0);
			last_q  <= head.last && head_done;
		end
	end

endmodule

// ===== rtl/magic_length_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// magic_length_packet_deframer_unit
// Sync-byte, length-prefixed packet deframer on a byte stream.
// ----------------------------------------------------------------------------
// raw: one byte per request; the block takes one byte every cycle while its
//   internal queue has room. bytes outside a packet are dropped until 0x99.
// pkt: one packet byte per request, first_byte on the sync byte, last_byte on
//   the final byte. packets shorter than four bytes by their length field are
//   rejected and the held bytes rescanned for sync.
// order: every byte is registered in the queue and then in the output register
//   before it appears; the header bytes are queued only once the fourth is taken.
// throughput: one byte per cycle in both directions, while the queue has room
//   for raw and pkt is ready.
// QUEUE_DEPTH entries separate the two; five cover a header entry plus the
//   body bytes queued behind it while it drains, so raw never stalls on its own.
//   when pkt stalls the queue fills and raw.ready drops, and a result waiting
//   in the output register never blocks intake while the queue has room.
// reset: queue and output register empty, the front end hunts for sync.
// ----------------------------------------------------------------------------
module magic_length_packet_deframer_unit #(
	parameter int QUEUE_DEPTH = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	mlpd_raw_if.sink  raw,
	mlpd_pkt_if.source pkt
);
	import mlpd_pkg::*;

	logic            push, pop;
	mlpd_entry_t     push_entry, head;
	mlpd_fifo_stat_t q_stat;

	mlpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.raw        (raw),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	mlpd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.rd_entry (head),
		.stat     (q_stat)
	);

	mlpd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.pkt    (pkt)
	);

	a_no_push_full : assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue written while full");

	a_no_pop_empty : assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue read while empty");

	a_first_not_last : assert property (@(posedge clk) disable iff (!arst_n)
		pkt.valid && pkt.first_byte |-> !pkt.last_byte)
		else $error("packet byte marked both first and last");

	a_hold_on_stall : assert property (@(posedge clk) disable iff (!arst_n)
		pkt.valid && !pkt.ready |=> pkt.valid && $stable(pkt.out_byte))
		else $error("output byte changed while stalled");

endmodule
